@@ hdl/csf_pkg.sv @@
`timescale 1ns / 1ps

package csf_pkg;

  // Item actions
  localparam logic ACT_WAIT   = 1'b0;
  localparam logic ACT_SIGNAL = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_CONTINUE  = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_NO_WAITER = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Semaphore count limits (9-bit two's complement)
  localparam logic signed [8:0] COUNT_MAX = 9'sd255;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

endpackage

@@ hdl/csf_if.sv @@
`timescale 1ns / 1ps

// Request channel: one wait or signal per beat
interface csf_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] process_id;

  modport source (output valid, action, process_id, input ready);
  modport sink   (input valid, action, process_id, output ready);
endinterface

// Result channel: one result per request
interface csf_out_if
  import csf_pkg::*;
;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [7:0]        released_id;
  logic signed [8:0] count_now;

  modport source (output valid, status, released_id, count_now, input ready);
  modport sink   (input valid, status, released_id, count_now, output ready);
endinterface

// Configuration write channel: initial count
interface csf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] initial_count;

  modport source (output valid, initial_count, input ready);
  modport sink   (input valid, initial_count, output ready);
endinterface

@@ hdl/counting_semaphore_fifo_unit.sv @@
`timescale 1ns / 1ps

// Counting semaphore with a FIFO queue of waiting process ids.
// in_ch  : request beats (action 0 = wait, 1 = signal, process_id for waits).
// out_ch : one result beat per request: status, released_id, count_now.
// cfg_ch : writing initial_count reloads the semaphore count; the queue is
//          kept. Always ready; write only while no request is in flight.
// Results: a result is registered in the cycle after its request is accepted,
// except when a signal releases a waiter: the waiter id is first read from
// the synchronous queue memory into rd_data_r, and then the result is registered.
// Throughput: one request per cycle while out_ch takes results, except around a
// release: no request is accepted while the head entry is read out of the memory.
// Reset (rst_n low, synchronous): count = 1, queue empty, no result pending.
// Queue contents are not cleared; they are never used before they are written.
// When out_ch stalls, the finished result holds in the output register and
// in_ch.ready drops until that beat is taken (a beat taken in the same cycle
// lets the next request in).
module counting_semaphore_fifo_unit
  import csf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  csf_in_if.sink        in_ch,
  csf_out_if.source     out_ch,
  csf_cfg_if.sink       cfg_ch
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int TOT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [TOT_W-1:0] TOT_FULL = TOT_W'(QUEUE_DEPTH);

  // Waiter id memory
  logic [7:0] waiter_mem [QUEUE_DEPTH];
  logic [7:0] rd_data_r;

  state_t            state_r, state_nxt;
  logic signed [8:0] count_r, count_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic signed [8:0] pend_count_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [7:0]        out_rel_r;
  logic signed [8:0] out_count_r;

  logic              in_fire;
  logic              push;
  logic              pop;
  status_t           status_c;
  logic signed [8:0] sig_count;

  assign in_ch.ready  = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.released_id = out_rel_r;
  assign out_ch.count_now   = out_count_r;

  // Count after a signal, saturating at the top
  assign sig_count = (count_r == COUNT_MAX) ? count_r : count_r + 9'sd1;

  // Decide the item's effect on count and queue
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    total_nxt = total_r;
    push      = 1'b0;
    pop       = 1'b0;
    status_c  = ST_CONTINUE;
    if (in_fire) begin
      if (in_ch.action == ACT_WAIT) begin
        if (count_r[8] || (count_r == 9'sd0)) begin
          if (total_r == TOT_FULL) begin
            status_c = ST_FULL;
          end else begin
            push      = 1'b1;
            count_nxt = count_r - 9'sd1;
            tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
            total_nxt = total_r + 1'b1;
            status_c  = ST_QUEUED;
          end
        end else begin
          count_nxt = count_r - 9'sd1;
          status_c  = ST_CONTINUE;
        end
      end else begin
        count_nxt = sig_count;
        if ((sig_count[8] || (sig_count == 9'sd0)) && (total_r != '0)) begin
          pop       = 1'b1;
          head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
          total_nxt = total_r - 1'b1;
          status_c  = ST_RELEASED;
        end else begin
          status_c  = ST_NO_WAITER;
        end
      end
    end
  end

  // Next controller state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (pop) state_nxt = S_POP;
      S_POP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Queue memory: write at tail on push, read head every cycle
  always_ff @(posedge clk) begin
    if (push) begin
      waiter_mem[tail_r] <= in_ch.process_id;
    end
    rd_data_r <= waiter_mem[head_r];
  end

  // Control state, count, queue pointers and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= 9'sd1;
      head_r      <= '0;
      tail_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      total_r <= total_nxt;
      if (cfg_ch.valid) begin
        count_r <= $signed({1'b0, cfg_ch.initial_count});
      end else begin
        count_r <= count_nxt;
      end
      if (state_r == S_POP) begin
        out_valid_r <= 1'b1;
      end else if (in_fire) begin
        out_valid_r <= !pop;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state_r == S_POP) begin
      out_status_r <= ST_RELEASED;
      out_rel_r    <= rd_data_r;
      out_count_r  <= pend_count_r;
    end else if (in_fire) begin
      out_status_r <= status_c;
      out_rel_r    <= 8'd0;
      out_count_r  <= count_nxt;
    end
    if (in_fire) begin
      pend_count_r <= count_nxt;
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

import csf_pkg::*;

// One result beat as the block should produce it
typedef struct {
  status_t           status;
  logic [7:0]        released_id;
  logic signed [8:0] count_now;
} sem_result_t;

// Tracks the semaphore count and the waiter queue, and queues the result
// that each accepted request must produce
class sem_scoreboard #(int DEPTH = 16);
  logic signed [8:0] count;
  logic [7:0]        waiter_ids[DEPTH];
  int                head;
  int                tail;
  int                total;
  int                errors;
  sem_result_t       expected_results[$];

  function new();
    count  = 9'sd1;
    head   = 0;
    tail   = 0;
    total  = 0;
    errors = 0;
  endfunction

  // Writing initial_count reloads only the count; waiters stay queued
  function void load_count(logic [7:0] value);
    count = $signed({1'b0, value});
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function int queued();
    return total;
  endfunction

  // Apply one accepted request and queue its result
  function void log_request(logic act, logic [7:0] pid);
    sem_result_t r;
    r.released_id = 8'h00;
    if (act == ACT_WAIT) begin
      // decrement would go negative: the caller has to queue
      if (count <= 0) begin
        if (total >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          waiter_ids[tail] = pid;
          tail = (tail + 1) % DEPTH;
          total++;
          count = count - 1;
          r.status = ST_QUEUED;
        end
      end else begin
        count = count - 1;
        r.status = ST_CONTINUE;
      end
    end else begin
      // count saturates at the top
      if (count < COUNT_MAX) count = count + 1;
      if (count <= 0 && total > 0) begin
        r.released_id = waiter_ids[head];
        head = (head + 1) % DEPTH;
        total--;
        r.status = ST_RELEASED;
      end else begin
        r.status = ST_NO_WAITER;
      end
    end
    r.count_now = count;
    expected_results.push_back(r);
  endfunction

  // Compare one result beat with the oldest expectation
  function void check_result(status_t st, logic [7:0] rid, logic signed [8:0] cnt);
    sem_result_t e;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result beat: status %0d released_id %0d count_now %0d",
               $time, st, rid, cnt);
      errors++;
      return;
    end
    e = expected_results.pop_front();
    if (st !== e.status) begin
      $display("%0t: status mismatch: expected %0d got %0d", $time, e.status, st);
      errors++;
    end
    if (rid !== e.released_id) begin
      $display("%0t: released_id mismatch: expected %0d got %0d",
               $time, e.released_id, rid);
      errors++;
    end
    if (cnt !== e.count_now) begin
      $display("%0t: count_now mismatch: expected %0d got %0d", $time, e.count_now, cnt);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int QDEPTH = 16;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 195;

  logic clk;
  logic rst_n;
  logic send_steady;
  logic take_steady;

  csf_in_if  in_ch();
  csf_out_if out_ch();
  csf_cfg_if cfg_ch();

  sem_scoreboard #(QDEPTH) sb;

  counting_semaphore_fifo_unit #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshakes hang
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Send one request beat; a random idle gap comes before it unless in a steady stretch
  task automatic send_req(input logic act, input logic [7:0] pid);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 49) == 0) send_steady = ~send_steady;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.process_id <= pid;
    do @(posedge clk); while (!in_ch.ready);
    sb.log_request(act, pid);
  endtask

  // Hold off requests until every expected result has come back
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write initial_count; only called with no request in flight
  task automatic write_count(input logic [7:0] value);
    @(negedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.initial_count <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.load_count(value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: random stalls, check each beat taken
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    take_steady  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = take_steady ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 47) == 0) take_steady = ~take_steady;
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      sb.check_result(out_ch.status, out_ch.released_id, out_ch.count_now);
    end
  end

  // Stimulus
  initial begin
    int base_bias;
    int bias;
    logic act;
    logic [7:0] cfg;

    sb = new();
    rst_n                = 1'b0;
    send_steady          = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.action         = ACT_WAIT;
    in_ch.process_id     = 8'h00;
    cfg_ch.valid         = 1'b0;
    cfg_ch.initial_count = 8'h00;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // count 1 after reset: continue, queue, release, nobody waiting
    send_req(ACT_WAIT, 8'h00);
    send_req(ACT_WAIT, 8'hFF);
    send_req(ACT_SIGNAL, 8'hA5);
    send_req(ACT_SIGNAL, 8'h5A);

    // fill the queue from count 0, then one wait past full
    settle();
    write_count(8'd0);
    for (int i = 0; i <= QDEPTH; i++) send_req(ACT_WAIT, 8'($urandom_range(0, 255)));
    send_req(ACT_SIGNAL, 8'h00);

    // reload the count while ids still wait, then signal at the top count
    settle();
    write_count(8'd255);
    send_req(ACT_SIGNAL, 8'hFF);

    // random phases, each from a fresh count
    for (int p = 0; p < PHASES; p++) begin
      settle();
      // a full queue with a reloaded count could never drain: free a slot first
      if (sb.queued() == QDEPTH) begin
        send_req(ACT_SIGNAL, 8'($urandom_range(0, 255)));
        settle();
      end
      case (p)
        0: begin cfg = 8'd0;   base_bias = 60; end
        1: begin cfg = 8'd255; base_bias = 85; end
        2: begin cfg = 8'd1;   base_bias = 50; end
        3: begin cfg = 8'd254; base_bias = 15; end
        4: begin cfg = 8'd0;   base_bias = 70; end
        6: begin cfg = 8'd128; base_bias = 85; end
        7: begin cfg = 8'd2;   base_bias = 40; end
        9: begin cfg = 8'd16;  base_bias = 65; end
        default: begin
          cfg = 8'($urandom_range(0, 255));
          base_bias = 75;
        end
      endcase
      write_count(cfg);
      bias = base_bias;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) begin
          case ($urandom_range(0, 4))
            0: bias = 20;
            1: bias = 50;
            2: bias = 80;
            default: bias = base_bias;
          endcase
        end
        if ($urandom_range(0, 39) == 0) settle();
        act = ($urandom_range(0, 99) < bias) ? ACT_WAIT : ACT_SIGNAL;
        send_req(act, 8'($urandom_range(0, 255)));
      end
    end

    settle();
    repeat (5) @(negedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/csf_pkg.sv
hdl/csf_if.sv
hdl/counting_semaphore_fifo_unit.sv
bench/testbench.sv
